[hdl/pps_pkg.sv]
// ----------------------------------------------------------------------------
// Pulse-period speedometer package
// Field widths, configuration register indexes, reset values and the
// configuration register bundle shared by the speedometer modules.
// ----------------------------------------------------------------------------
package pps_pkg;

	// field widths
	localparam int DEB_W      = 24;
	localparam int STOP_W     = 48;
	localparam int NUM_W      = 48;
	localparam int DPP_W      = 24;
	localparam int SPEED_W    = 16;
	localparam int COUNT_W    = 32;
	localparam int DIST_W     = 56;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NUMERATOR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIST_PULSE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LO    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_HI    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TEST_ENABLE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TEST_START  = 3'd7;

	// register reset values
	localparam logic [DEB_W-1:0]   DEBOUNCE_RST = 24'd1000;
	localparam logic [STOP_W-1:0]  STOP_RST     = 48'd2000000;
	localparam logic [SPEED_W-1:0] SPEED_HI_RST = 16'd30000;

	// sweep saturation limit
	localparam logic [SPEED_W-1:0] SPEED_TOP = '1;

	typedef struct packed {
		logic [DEB_W-1:0]   debounce_us;
		logic [STOP_W-1:0]  stop_timeout_us;
		logic [NUM_W-1:0]   speed_numerator;
		logic [DPP_W-1:0]   distance_per_pulse_um;
		logic [SPEED_W-1:0] speed_lo;
		logic [SPEED_W-1:0] speed_hi;
		logic               test_enable;
		logic [SPEED_W-1:0] test_start_speed;
	} cfg_regs_t;

	// test mode switch written this cycle
	typedef struct packed {
		logic wr;
		logic on;
	} test_evt_t;

endpackage

[hdl/pulse_period_speedometer.sv]
// An accepted sample is registered, then passes through the evaluate,
// divide (only when speed is recomputed), multiply and output states; the
// radix-2 divider sets the longer path. One item is in work at a time: the
// next is taken once the result register is written, later while a waiting
// result holds the output register. Asynchronous active-low reset clears all
// measurement state and loads the configuration reset values.
// ----------------------------------------------------------------------------
// Pulse-period speedometer
// Debounces timestamped pin samples, counts falling edges, accumulates
// distance and derives speed from the edge period with a single divider,
// with decay, stop timeout and a triangle sweep test mode.
// ----------------------------------------------------------------------------
module pulse_period_speedometer #(
	parameter int TIME_WIDTH = 48
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// sample channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [TIME_WIDTH-1:0]          now_us,
	input  logic                           pin_level,
	// result channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [pps_pkg::SPEED_W-1:0]    speed_centi_kmh,
	output logic [pps_pkg::COUNT_W-1:0]    pulse_count,
	output logic [pps_pkg::DIST_W-1:0]     distance_um,
	output logic                           edge_seen,
	// configuration channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pps_pkg::CFG_DATA_W-1:0] cfg_data
);

	import pps_pkg::*;

	localparam int CMP_W = (TIME_WIDTH > STOP_W) ? TIME_WIDTH : STOP_W;

	typedef enum logic [2:0] {S_IDLE, S_EVAL, S_DIV, S_MUL, S_OUT} state_t;

	cfg_regs_t regs;
	test_evt_t test_evt;

	state_t state_q;

	// sample
	logic [TIME_WIDTH-1:0] now_q;
	logic                  pin_q;

	// measurement state
	logic                  deb_level_q;
	logic                  prev_level_q;
	logic [TIME_WIDTH-1:0] deb_stamp_q;
	logic [TIME_WIDTH-1:0] last_edge_q;
	logic                  edge_valid_q;
	logic [TIME_WIDTH-1:0] last_period_q;
	logic [COUNT_W-1:0]    edge_count_q;
	logic [SPEED_W-1:0]    held_speed_q;
	logic [SPEED_W-1:0]    sweep_speed_q;
	logic                  sweep_down_q;
	logic                  edge_q;
	logic [DIST_W-1:0]     dist_q;

	// result register
	logic                  out_valid_q;
	logic [SPEED_W-1:0]    out_speed_q;
	logic [COUNT_W-1:0]    out_count_q;
	logic [DIST_W-1:0]     out_dist_q;
	logic                  out_edge_q;

	// evaluation terms
	logic [TIME_WIDTH-1:0] deb_age;
	logic                  deb_take;
	logic                  new_level;
	logic                  fall;
	logic [TIME_WIDTH-1:0] since;
	logic                  past_stop;
	logic                  need_div;
	logic [SPEED_W-1:0]    sweep_next;
	logic                  sweep_flip;
	logic [SPEED_W-1:0]    test_start_clamped;

	logic                  div_start;
	logic                  div_done;
	logic [NUM_W-1:0]      div_quot;

	// raise to the lower bound, then cut to the upper bound
	function automatic logic [SPEED_W-1:0] clamp_speed(
		input logic [NUM_W-1:0]   v,
		input logic [SPEED_W-1:0] lo,
		input logic [SPEED_W-1:0] hi
	);
		logic [NUM_W-1:0] r;
		r = v;
		if (r < NUM_W'(lo))
			r = NUM_W'(lo);
		if (r > NUM_W'(hi))
			r = NUM_W'(hi);
		return r[SPEED_W-1:0];
	endfunction

	pps_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.regs     (regs),
		.test_evt (test_evt)
	);

	pps_div #(
		.DIVIDEND_W(NUM_W),
		.DIVISOR_W (TIME_WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(regs.speed_numerator),
		.divisor (since),
		.done    (div_done),
		.quotient(div_quot)
	);

	// debounce, edge detection and speed decisions for the held sample
	always_comb begin
		deb_age   = now_q - deb_stamp_q;
		deb_take  = (pin_q != deb_level_q) && (deb_age > TIME_WIDTH'(regs.debounce_us));
		new_level = deb_take ? pin_q : deb_level_q;
		fall      = prev_level_q & ~new_level;
		since     = now_q - last_edge_q;
		past_stop = CMP_W'(since) > CMP_W'(regs.stop_timeout_us);
		if (regs.test_enable)
			need_div = 1'b0;
		else if (fall)
			need_div = edge_valid_q && (since != '0);
		else
			need_div = edge_valid_q && !past_stop && (since > last_period_q);
		div_start = (state_q == S_EVAL) && need_div;
	end

	// triangle sweep step and clamped sweep start speed
	always_comb begin
		sweep_next = sweep_speed_q;
		if (sweep_down_q) begin
			if (sweep_speed_q != '0)
				sweep_next = sweep_speed_q - SPEED_W'(1);
		end else begin
			if (sweep_speed_q != SPEED_TOP)
				sweep_next = sweep_speed_q + SPEED_W'(1);
		end
		sweep_flip = (sweep_next <= regs.speed_lo) || (sweep_next >= regs.speed_hi);
		test_start_clamped = clamp_speed(NUM_W'(regs.test_start_speed),
			regs.speed_lo, regs.speed_hi);
	end

	// sequencer, measurement state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			now_q         <= '0;
			pin_q         <= 1'b0;
			deb_level_q   <= 1'b0;
			prev_level_q  <= 1'b0;
			deb_stamp_q   <= '0;
			last_edge_q   <= '0;
			edge_valid_q  <= 1'b0;
			last_period_q <= '0;
			edge_count_q  <= '0;
			held_speed_q  <= '0;
			sweep_speed_q <= '0;
			sweep_down_q  <= 1'b0;
			edge_q        <= 1'b0;
			dist_q        <= '0;
			out_valid_q   <= 1'b0;
			out_speed_q   <= '0;
			out_count_q   <= '0;
			out_dist_q    <= '0;
			out_edge_q    <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one replaces it
			if (out_valid_q && out_ready && (state_q != S_OUT))
				out_valid_q <= 1'b0;

			// test mode switch: load the sweep or clear the measurement
			if (test_evt.wr) begin
				if (test_evt.on) begin
					sweep_speed_q <= test_start_clamped;
					held_speed_q  <= test_start_clamped;
				end else begin
					deb_level_q   <= 1'b0;
					prev_level_q  <= 1'b0;
					edge_valid_q  <= 1'b0;
					last_edge_q   <= '0;
					last_period_q <= '0;
					edge_count_q  <= '0;
					held_speed_q  <= '0;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						now_q   <= now_us;
						pin_q   <= pin_level;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					edge_q <= 1'b0;
					if (regs.test_enable) begin
						sweep_speed_q <= sweep_next;
						held_speed_q  <= sweep_next;
						if (sweep_flip)
							sweep_down_q <= ~sweep_down_q;
					end else begin
						deb_level_q  <= new_level;
						prev_level_q <= new_level;
						if (pin_q == deb_level_q)
							deb_stamp_q <= now_q;
						if (fall) begin
							edge_q       <= 1'b1;
							edge_count_q <= edge_count_q + COUNT_W'(1);
							if (edge_valid_q) begin
								last_period_q <= since;
								if (since == '0)
									held_speed_q <= '0;
							end
							last_edge_q  <= now_q;
							edge_valid_q <= 1'b1;
						end else if (!edge_valid_q || past_stop) begin
							held_speed_q <= '0;
						end
					end
					state_q <= need_div ? S_DIV : S_MUL;
				end
				S_DIV: begin
					if (div_done) begin
						held_speed_q <= clamp_speed(div_quot, regs.speed_lo, regs.speed_hi);
						state_q      <= S_MUL;
					end
				end
				S_MUL: begin
					dist_q  <= DIST_W'(edge_count_q) * DIST_W'(regs.distance_per_pulse_um);
					state_q <= S_OUT;
				end
				S_OUT: begin
					// hold until the result register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_speed_q <= held_speed_q;
						out_count_q <= edge_count_q;
						out_dist_q  <= dist_q;
						out_edge_q  <= edge_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready        = (state_q == S_IDLE);
	assign out_valid       = out_valid_q;
	assign speed_centi_kmh = out_speed_q;
	assign pulse_count     = out_count_q;
	assign distance_um     = out_dist_q;
	assign edge_seen       = out_edge_q;

endmodule

[hdl/pps_div.sv]
// ----------------------------------------------------------------------------
// Pulse-period speedometer divider
// Radix-2 restoring divider, one quotient bit per cycle. A start pulse loads
// the operands; done pulses for one cycle with the quotient ready.
// ----------------------------------------------------------------------------
module pps_div #(
	parameter int DIVIDEND_W = 48,
	parameter int DIVISOR_W  = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  den_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIVISOR_W:0] shifted;
	logic [DIVISOR_W:0] trial;
	logic               fits;

	// shift in the next dividend bit and try the subtraction
	always_comb begin
		shifted = {rem_q, quo_q[DIVIDEND_W-1]};
		trial   = shifted - {1'b0, den_q};
		fits    = ~trial[DIVISOR_W];
	end

	// iterate one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			den_q  <= divisor;
			cnt_q  <= CNT_W'(DIVIDEND_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q <= fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[hdl/pps_cfg.sv]
// ----------------------------------------------------------------------------
// Pulse-period speedometer configuration registers
// Holds the eight configuration registers and flags writes of the test
// mode switch so the measurement state can be loaded or cleared.
// ----------------------------------------------------------------------------
module pps_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pps_pkg::CFG_DATA_W-1:0] cfg_data,
	output pps_pkg::cfg_regs_t             regs,
	output pps_pkg::test_evt_t             test_evt
);

	import pps_pkg::*;

	cfg_regs_t regs_q;

	// writes are always taken
	assign cfg_ready = 1'b1;

	// flag a test mode switch write, whatever its value
	always_comb begin
		test_evt.wr = cfg_valid && (cfg_index == REG_TEST_ENABLE);
		test_evt.on = cfg_data[0];
	end

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.debounce_us           <= DEBOUNCE_RST;
			regs_q.stop_timeout_us       <= STOP_RST;
			regs_q.speed_numerator       <= '0;
			regs_q.distance_per_pulse_um <= '0;
			regs_q.speed_lo              <= '0;
			regs_q.speed_hi              <= SPEED_HI_RST;
			regs_q.test_enable           <= 1'b0;
			regs_q.test_start_speed      <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEBOUNCE:    regs_q.debounce_us <= cfg_data[DEB_W-1:0];
				REG_STOP:        regs_q.stop_timeout_us <= cfg_data[STOP_W-1:0];
				REG_NUMERATOR:   regs_q.speed_numerator <= cfg_data[NUM_W-1:0];
				REG_DIST_PULSE:  regs_q.distance_per_pulse_um <= cfg_data[DPP_W-1:0];
				REG_SPEED_LO:    regs_q.speed_lo <= cfg_data[SPEED_W-1:0];
				REG_SPEED_HI:    regs_q.speed_hi <= cfg_data[SPEED_W-1:0];
				REG_TEST_ENABLE: regs_q.test_enable <= cfg_data[0];
				REG_TEST_START:  regs_q.test_start_speed <= cfg_data[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule
